>>> hdl/asbox_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// asbox_pkg
// Types, constants and GF(2^8) helpers for the AES S-box word substitute.
// -----------------------------------------------------------------------------
package asbox_pkg;

   localparam int WORD_BYTES = 4;
   localparam int WORD_BITS  = 8 * WORD_BYTES;

   typedef logic [7:0]                  byte_type;
   typedef logic [WORD_BITS-1:0]        word_type;
   typedef byte_type [WORD_BYTES-1:0]   lanes_type;

   // Reduction polynomial x^8+x^4+x^3+x+1 without the x^8 term
   localparam byte_type GF_POLY    = 8'h1B;
   localparam byte_type AFFINE_ADD = 8'h63;

   // GF(2^8) product: shift-and-add, eight narrow steps
   function automatic byte_type gf_mul(input byte_type a, input byte_type b);
      byte_type acc;
      byte_type sh;
      acc = '0;
      sh  = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ sh;
         end
         sh = sh[7] ? ({sh[6:0], 1'b0} ^ GF_POLY) : {sh[6:0], 1'b0};
      end
      return acc;
   endfunction

   function automatic byte_type gf_sq(input byte_type a);
      return gf_mul(a, a);
   endfunction

   function automatic byte_type rotl8(input byte_type a, input int unsigned n);
      return byte_type'((a << n) | (a >> (8 - n)));
   endfunction

   // AES affine output map applied to the field inverse
   function automatic byte_type sbox_affine(input byte_type x);
      return x ^ rotl8(x, 1) ^ rotl8(x, 2) ^ rotl8(x, 3) ^ rotl8(x, 4) ^ AFFINE_ADD;
   endfunction

endpackage
`default_nettype wire

>>> hdl/aes_sbox_word_substitute.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: stage 1, stage 2 and stage 3 registers; stage 3 drives the response.
// Throughput: one word per cycle while rsp_tready does not stall the output; each
// of the three stages is about one GF(2^8) multiply deep per lane (x^3, then x^15
// and x^14, then x^254 with the affine map).
// Reset: synchronous, clears the stage valid bits; payload registers keep data.
// -----------------------------------------------------------------------------
// aes_sbox_word_substitute
// Pipelined AES forward S-box on the lane bytes of a 32-bit word (others read zero),
// computed as the field inverse x^254 by an addition chain, then the affine map.
// -----------------------------------------------------------------------------
module aes_sbox_word_substitute #(
   parameter int LANE_BYTES = 4
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire  asbox_pkg::word_type  req_tdata,   // [31:0] data_word
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output asbox_pkg::word_type        rsp_tdata    // [31:0] subst_word
);
   import asbox_pkg::*;

   localparam int ACTIVE_LANES = (LANE_BYTES < WORD_BYTES) ? LANE_BYTES : WORD_BYTES;
   localparam int ACTIVE_BITS  = 8 * ACTIVE_LANES;
   localparam word_type LANE_MASK =
      (ACTIVE_BITS >= WORD_BITS) ? {WORD_BITS{1'b1}}
                                 : word_type'((64'd1 << ACTIVE_BITS) - 64'd1);

   logic      s1_valid_ff, s1_valid_in;
   logic      s2_valid_ff, s2_valid_in;
   logic      s3_valid_ff, s3_valid_in;
   logic      s1_ready, s2_ready, s3_ready;
   logic      s1_load, s2_load, s3_load;

   lanes_type s1_x_ff,   s1_x_in;    // x
   lanes_type s1_p3_ff,  s1_p3_in;   // x^3
   lanes_type s2_p14_ff, s2_p14_in;  // x^14
   lanes_type s2_p15_ff, s2_p15_in;  // x^15
   lanes_type s3_out_ff, s3_out_in;  // S-box result

   // A stage may take new data when empty or when it drains this cycle
   assign s3_ready   = !s3_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   assign s1_load = req_tvalid && s1_ready;
   assign s2_load = s1_valid_ff && s2_ready;
   assign s3_load = s2_valid_ff && s3_ready;

   assign s1_valid_in = s1_ready ? req_tvalid  : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_comb begin
      byte_type x;
      byte_type p12;
      byte_type p240;
      for (int i = 0; i < WORD_BYTES; i++) begin
         x          = req_tdata[8*i +: 8];
         s1_x_in[i] = x;
         s1_p3_in[i] = gf_mul(gf_sq(x), x);

         p12          = gf_sq(gf_sq(s1_p3_ff[i]));
         s2_p15_in[i] = gf_mul(p12, s1_p3_ff[i]);
         s2_p14_in[i] = gf_mul(p12, gf_sq(s1_x_ff[i]));

         p240          = gf_sq(gf_sq(gf_sq(gf_sq(s2_p15_ff[i]))));
         s3_out_in[i]  = (i < ACTIVE_LANES) ? sbox_affine(gf_mul(p240, s2_p14_ff[i])) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_x_ff  <= s1_x_in;
         s1_p3_ff <= s1_p3_in;
      end
      if (s2_load) begin
         s2_p14_ff <= s2_p14_in;
         s2_p15_ff <= s2_p15_in;
      end
      if (s3_load) begin
         s3_out_ff <= s3_out_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = word_type'(s3_out_ff);

   a_drain_ready : assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while the output side accepts");

   a_stage_advance : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_ready) |=> s2_valid_ff)
      else $error("request lost between stage 1 and stage 2");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_unused_lanes : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata & ~LANE_MASK) == '0))
      else $error("byte without a lane is not zero");

endmodule
`default_nettype wire

>>> test/sbox_word_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sbox_word_checker
// Watches both stream channels of the S-box word substitute. Predicts each
// response from the accepted request and compares it in order.
// -----------------------------------------------------------------------------
module sbox_word_checker #(
   parameter int LANE_BYTES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  asbox_pkg::word_type  req_tdata,   // [31:0] data_word
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  asbox_pkg::word_type  rsp_tdata,   // [31:0] subst_word
   output int                   mismatch_count,
   output int                   pending_words,
   output int                   words_sent,
   output int                   words_received
);
   import asbox_pkg::*;

   byte_type sbox_lut [256];
   word_type subst_words_q [$];

   initial begin
      mismatch_count = 0;
      pending_words  = 0;
      words_sent     = 0;
      words_received = 0;
      sbox_lut = '{
         8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
         8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
         8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
         8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
         8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
         8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
         8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
         8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
         8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
         8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
         8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
         8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
         8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
         8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
         8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
         8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
         8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
         8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
         8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
         8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
         8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
         8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
         8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
         8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
         8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
         8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
         8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
         8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
         8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
         8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
         8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
         8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
      };
   end

   // Byte positions without a lane read back as zero
   function automatic word_type substitute_lanes(input word_type data_word);
      word_type subst;
      subst = '0;
      for (int lane = 0; lane < WORD_BYTES; lane++) begin
         if (lane < LANE_BYTES) begin
            subst[8*lane +: 8] = sbox_lut[data_word[8*lane +: 8]];
         end
      end
      return subst;
   endfunction

   always @(posedge clock) begin
      word_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            words_received++;
            if (subst_words_q.size() == 0) begin
               $error("subst_word with no request pending: expected none, actual %h",
                      rsp_tdata);
               mismatch_count++;
            end else begin
               want = subst_words_q.pop_front();
               if (rsp_tdata !== want) begin
                  $error("subst_word mismatch: expected %h, actual %h", want, rsp_tdata);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            subst_words_q.push_back(substitute_lanes(req_tdata));
            words_sent++;
         end
      end
      pending_words = subst_words_q.size();
   end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Stream stimulus for the S-box word substitute: corner words, a sweep of all
// byte values in every lane, then random words under varied flow control.
// -----------------------------------------------------------------------------
module tb;
   import asbox_pkg::*;

   localparam int LANE_BYTES   = 4;
   localparam int RESET_CYCLES = 7;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_WORDS  = 84;

   typedef enum int {
      PH_FLOW,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH,
      PH_HOLD
   } phase_type;

   logic      clock      = 1'b0;
   logic      reset      = 1'b1;
   logic      req_tvalid = 1'b0;
   word_type  req_tdata  = '0;
   logic      req_tready;
   logic      rsp_tvalid;
   logic      rsp_tready = 1'b0;
   word_type  rsp_tdata;

   phase_type phase          = PH_FLOW;
   int        send_idle_pct  = 0;
   int        recv_stall_pct = 0;
   bit        hold_done      = 1'b0;
   int        quiet_cycles   = 0;

   int        mismatch_count;
   int        pending_words;
   int        words_sent;
   int        words_received;

   word_type  corner_words [12] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0302_0100, 32'h5252_5252,
      32'h0101_0101, 32'h8080_8080, 32'h7F7F_7F7F, 32'hAAAA_AAAA,
      32'h5555_5555, 32'hFF00_FF00, 32'h00FF_00FF, 32'h5300_52FF
   };

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   aes_sbox_word_substitute #(
      .LANE_BYTES (LANE_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sbox_word_checker #(
      .LANE_BYTES (LANE_BYTES)
   ) sbox_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_words  (pending_words),
      .words_sent     (words_sent),
      .words_received (words_received)
   );

   // Receiver: random stalls; one long hold-off in the pressure phase
   initial begin
      forever begin
         @(posedge clock);
         if (phase == PH_HOLD && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no request or response accepted for %0d cycles", IDLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Mix fully random words with words built from edge byte values
   function automatic word_type random_word();
      word_type w;
      w = $urandom;
      if ($urandom_range(1) == 0) begin
         for (int lane = 0; lane < WORD_BYTES; lane++) begin
            case ($urandom_range(3))
               0: w[8*lane +: 8] = 8'h00;
               1: w[8*lane +: 8] = 8'hFF;
               2: w[8*lane +: 8] = 8'h52;
               default: ;
            endcase
         end
      end
      return w;
   endfunction

   // Hold the request until accepted; idle gaps come before it
   task automatic send_word(input word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic run_phase(input phase_type p, input int send_pct, input int recv_pct,
                            input int count);
      phase          = p;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) send_word(random_word());
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (corner_words[i]) send_word(corner_words[i]);

      // Every byte value through every lane
      for (int i = 0; i < 256; i++) begin
         send_word({8'(i + 192), 8'(i + 128), 8'(i + 64), 8'(i)});
      end

      run_phase(PH_SEND_IDLE, 83, 0, PHASE_WORDS);
      run_phase(PH_RECV_STALL, 0, 83, PHASE_WORDS);
      run_phase(PH_BOTH, 27, 27, PHASE_WORDS);
      run_phase(PH_HOLD, 0, 0, PHASE_WORDS);
      run_phase(PH_FLOW, 0, 0, PHASE_WORDS / 2);
      req_tvalid <= 1'b0;

      do @(negedge clock); while (pending_words != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered corner words, a full byte sweep per lane and random words under");
      $display("free flow, sender gaps, receiver stalls and a long hold-off: %0d in, %0d out",
               words_sent, words_received);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
